FILE: design/trme_pkg.sv
// Package for the two-run merge engine: run depths, pointer widths,
// request and status codes and the controller state type.
// No dependencies.
package trme_pkg;

  localparam int KEY_W       = 64;
  localparam int RUN_A_DEPTH = 4096;
  localparam int RUN_B_DEPTH = 1024;

  // Slot address widths; pointers carry one extra wrap bit.
  localparam int RA_AW = $clog2(RUN_A_DEPTH);
  localparam int RB_AW = $clog2(RUN_B_DEPTH);
  localparam int RA_PW = RA_AW + 1;
  localparam int RB_PW = RB_AW + 1;

  localparam logic [RA_PW-1:0] RA_FULL = RA_PW'(RUN_A_DEPTH);
  localparam logic [RB_PW-1:0] RB_FULL = RB_PW'(RUN_B_DEPTH);

  typedef enum logic [1:0] {
    REQ_LOAD_A = 2'd0,
    REQ_LOAD_B = 2'd1,
    REQ_PULL   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_EMIT    = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_LOADED  = 3'd2,
    ST_DROPPED = 3'd3,
    ST_CLEARED = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_PULL = 1'b1
  } state_t;

endpackage

FILE: design/trme_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Generic; used for both run stores. No dependencies.
module trme_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/two_run_merge_engine.sv
// Top level of the two-run merge engine: pointer registers, controller and
// output register around two trme_ram stores. Depends on trme_pkg, trme_ram.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------
//   request | req_valid, req_ready | req_type, key_in
//   result  | rsp_valid, rsp_ready | key_out, status, from_run_b, last
//
// Load, clear and a pull on two empty runs: result registered at the accepting
// edge. A pull that emits: the head keys are read from both stores in the
// accepting cycle and compared once the read data lands.
// One request is in flight at a time; a new one is taken while the previous
// result still waits, provided the output register frees at that edge.
// Synchronous active-high reset empties both runs; stores are not cleared.
module two_run_merge_engine
  import trme_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  logic [1:0]       req_type,
  input  logic [KEY_W-1:0] key_in,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output logic [KEY_W-1:0] key_out,
  output logic [2:0]       status,
  output logic             from_run_b,
  output logic             last
);

  state_t state, state_next;

  logic [RA_PW-1:0] a_head, a_tail, a_fill;
  logic [RB_PW-1:0] b_head, b_tail, b_fill;
  logic a_empty, b_empty, a_full, b_full, a_one, b_one;

  logic             accept;
  req_t             req;
  logic             rd_en;
  logic             a_we, b_we;
  logic [KEY_W-1:0] a_rdata, b_rdata;
  logic             take_b;

  logic             rsp_load;
  logic [KEY_W-1:0] key_next;
  status_t          status_next;
  logic             from_next, last_next;

  assign req     = req_t'(req_type);
  assign accept  = req_valid && req_ready;

  assign a_fill  = a_tail - a_head;
  assign b_fill  = b_tail - b_head;
  assign a_empty = (a_tail == a_head);
  assign b_empty = (b_tail == b_head);
  assign a_full  = (a_fill == RA_FULL);
  assign b_full  = (b_fill == RB_FULL);
  assign a_one   = (a_fill == RA_PW'(1));
  assign b_one   = (b_fill == RB_PW'(1));

  assign a_we = accept && (req == REQ_LOAD_A) && !a_full;
  assign b_we = accept && (req == REQ_LOAD_B) && !b_full;

  trme_ram #(.DEPTH(RUN_A_DEPTH), .WIDTH(KEY_W)) u_run_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_tail[RA_AW-1:0]),
    .wdata (key_in),
    .re    (rd_en),
    .raddr (a_head[RA_AW-1:0]),
    .rdata (a_rdata)
  );

  trme_ram #(.DEPTH(RUN_B_DEPTH), .WIDTH(KEY_W)) u_run_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_tail[RB_AW-1:0]),
    .wdata (key_in),
    .re    (rd_en),
    .raddr (b_head[RB_AW-1:0]),
    .rdata (b_rdata)
  );

  // B wins ties; an empty run never wins.
  assign take_b = !b_empty && (a_empty || (b_rdata <= a_rdata));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (req == REQ_PULL) && !(a_empty && b_empty)) begin
          state_next = S_PULL;
        end
      end
      S_PULL:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    rd_en     = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = !rsp_valid || rsp_ready;
        rd_en     = req_valid && req_ready && (req == REQ_PULL);
      end
      S_PULL:  req_ready = 1'b0;
      default: req_ready = 1'b0;
    endcase
  end

  always_comb begin
    rsp_load    = 1'b0;
    key_next    = '0;
    status_next = ST_EMIT;
    from_next   = 1'b0;
    last_next   = 1'b0;
    if (state == S_PULL) begin
      rsp_load = 1'b1;
      if (take_b) begin
        key_next  = b_rdata;
        from_next = 1'b1;
        last_next = a_empty && b_one;
      end else begin
        key_next  = a_rdata;
        last_next = b_empty && a_one;
      end
    end else if (accept) begin
      case (req)
        REQ_LOAD_A: begin
          rsp_load    = 1'b1;
          status_next = a_full ? ST_DROPPED : ST_LOADED;
        end
        REQ_LOAD_B: begin
          rsp_load    = 1'b1;
          status_next = b_full ? ST_DROPPED : ST_LOADED;
        end
        REQ_PULL: begin
          // Non-empty pulls answer from the read state instead.
          rsp_load    = a_empty && b_empty;
          status_next = ST_EMPTY;
        end
        default: begin
          rsp_load    = 1'b1;
          status_next = ST_CLEARED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_head <= '0;
      a_tail <= '0;
      b_head <= '0;
      b_tail <= '0;
    end else if (state == S_PULL) begin
      if (take_b) begin
        b_head <= b_head + RB_PW'(1);
      end else begin
        a_head <= a_head + RA_PW'(1);
      end
    end else if (accept && (req == REQ_CLEAR)) begin
      a_head <= '0;
      a_tail <= '0;
      b_head <= '0;
      b_tail <= '0;
    end else begin
      if (a_we) begin
        a_tail <= a_tail + RA_PW'(1);
      end
      if (b_we) begin
        b_tail <= b_tail + RB_PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      key_out    <= key_next;
      status     <= status_next;
      from_run_b <= from_next;
      last       <= last_next;
    end
  end

endmodule

FILE: design/trme_checker.sv
// Port-level checker for the two-run merge engine, bound to the top level.
// Depends on trme_pkg.
module trme_checker
  import trme_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic [1:0]       req_type,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic [KEY_W-1:0] key_out,
  input logic [2:0]       status,
  input logic             from_run_b,
  input logic             last
);

  // Hold a stalled result.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(key_out) && $stable(status))
    else $error("result dropped or changed while stalled");

  // Drop all pull fields on results that emit nothing.
  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_EMIT) |-> (key_out == '0) && !from_run_b && !last)
    else $error("non-emit result carries key fields");

  a_clear_resp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_type == REQ_CLEAR)
    |=> rsp_valid && (status == ST_CLEARED))
    else $error("clear not answered in one cycle");

  a_load_resp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && ((req_type == REQ_LOAD_A) || (req_type == REQ_LOAD_B))
    |=> rsp_valid && ((status == ST_LOADED) || (status == ST_DROPPED)))
    else $error("load not answered in one cycle");

endmodule

bind two_run_merge_engine trme_checker u_trme_checker (.*);
